// ----- rtl/core/u8je_pkg.sv -----
package u8je_pkg;

  // Command slots: opening quote, flushed held bytes, current byte or raw
  // sequence, bytes flushed at string end, closing quote.
  localparam int NumSlots  = 12;
  localparam int SlotIdxW  = 4;
  localparam int SlotOpen  = 0;
  localparam int SlotPre   = 1;
  localparam int SlotMid   = 4;
  localparam int SlotPost  = 8;
  localparam int SlotClose = 11;

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5c;

  // How one unit expands on the output side
  typedef enum logic [1:0] {
    KIND_LIT,    // byte as is
    KIND_CLOSE,  // closing quote
    KIND_ESC2,   // backslash plus escape letter
    KIND_HEX     // \u00hh
  } unit_kind_t;

  typedef struct packed {
    unit_kind_t  kind;
    logic [7:0]  val;
  } unit_t;

  typedef struct packed {
    logic [NumSlots-1:0]  vld;
    unit_t [NumSlots-1:0] units;
  } cmd_t;

endpackage

// ----- rtl/core/u8je_front.sv -----
module u8je_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [7:0]        data_byte,
  input  logic              byte_present,
  input  logic              string_end,
  output logic              cmd_push,
  output u8je_pkg::cmd_t    cmd
);

  // String and UTF-8 hold state
  logic       open_r, open_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [7:0] lead_r, cont0_r, cont1_r;
  logic [7:0] lead_nxt, cont0_nxt, cont1_nxt;
  logic [2:0] len;
  logic       ok;
  logic       do_fresh;
  logic [7:0] esc;

  function automatic logic [2:0] seq_len(input logic [7:0] v);
    logic [2:0] r;
    r = 3'd0;
    if (v >= 8'hc2 && v <= 8'hdf) r = 3'd2;
    else if (v >= 8'he0 && v <= 8'hef) r = 3'd3;
    else if (v >= 8'hf0 && v <= 8'hf4) r = 3'd4;
    return r;
  endfunction

  // Second byte has tighter ranges for a few leads
  function automatic logic next_ok(input logic [7:0] ld, input logic second,
                                   input logic [7:0] v);
    logic r;
    r = (v >= 8'h80 && v <= 8'hbf);
    if (second) begin
      if (ld == 8'he0) r = (v >= 8'ha0 && v <= 8'hbf);
      else if (ld == 8'hed) r = (v >= 8'h80 && v <= 8'h9f);
      else if (ld == 8'hf0) r = (v >= 8'h90 && v <= 8'hbf);
      else if (ld == 8'hf4) r = (v >= 8'h80 && v <= 8'h8f);
    end
    return r;
  endfunction

  function automatic logic [7:0] esc_char(input logic [7:0] v);
    logic [7:0] r;
    unique case (v)
      8'h22:   r = u8je_pkg::ChQuote;
      8'h5c:   r = u8je_pkg::ChBslash;
      8'h08:   r = 8'h62;  // b
      8'h0c:   r = 8'h66;  // f
      8'h0a:   r = 8'h6e;  // n
      8'h0d:   r = 8'h72;  // r
      8'h09:   r = 8'h74;  // t
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic u8je_pkg::unit_t mk(input u8je_pkg::unit_kind_t k,
                                         input logic [7:0] v);
    u8je_pkg::unit_t u;
    u.kind = k;
    u.val  = v;
    return u;
  endfunction

  // Classify the item and build its command
  always_comb begin
    cmd       = '0;
    open_nxt  = open_r;
    cnt_nxt   = cnt_r;
    lead_nxt  = lead_r;
    cont0_nxt = cont0_r;
    cont1_nxt = cont1_r;
    do_fresh  = 1'b0;
    len       = seq_len(lead_r);
    ok        = (len != 3'd0) && ({1'b0, cnt_r} < len) &&
                next_ok(lead_r, cnt_r == 2'd1, data_byte);
    esc       = esc_char(data_byte);

    if ((byte_present || string_end) && !open_r) begin
      cmd.vld[u8je_pkg::SlotOpen]   = 1'b1;
      cmd.units[u8je_pkg::SlotOpen] = mk(u8je_pkg::KIND_LIT, u8je_pkg::ChQuote);
      open_nxt = 1'b1;
    end

    if (byte_present) begin
      if (cnt_r == 2'd0) begin
        do_fresh = 1'b1;
      end else if (ok && ({1'b0, cnt_r} + 3'd1 == len)) begin
        // sequence complete: pass raw
        cmd.vld[u8je_pkg::SlotMid]     = 1'b1;
        cmd.units[u8je_pkg::SlotMid]   = mk(u8je_pkg::KIND_LIT, lead_r);
        cmd.vld[u8je_pkg::SlotMid+1]   = (cnt_r >= 2'd2);
        cmd.units[u8je_pkg::SlotMid+1] = mk(u8je_pkg::KIND_LIT, cont0_r);
        cmd.vld[u8je_pkg::SlotMid+2]   = (cnt_r == 2'd3);
        cmd.units[u8je_pkg::SlotMid+2] = mk(u8je_pkg::KIND_LIT, cont1_r);
        cmd.vld[u8je_pkg::SlotMid+3]   = 1'b1;
        cmd.units[u8je_pkg::SlotMid+3] = mk(u8je_pkg::KIND_LIT, data_byte);
        cnt_nxt = 2'd0;
      end else if (ok) begin
        if (cnt_r == 2'd1) cont0_nxt = data_byte;
        else cont1_nxt = data_byte;
        cnt_nxt = cnt_r + 2'd1;
      end else begin
        // broken sequence: escape held bytes, then redo this byte
        cmd.vld[u8je_pkg::SlotPre]     = 1'b1;
        cmd.units[u8je_pkg::SlotPre]   = mk(u8je_pkg::KIND_HEX, lead_r);
        cmd.vld[u8je_pkg::SlotPre+1]   = (cnt_r >= 2'd2);
        cmd.units[u8je_pkg::SlotPre+1] = mk(u8je_pkg::KIND_HEX, cont0_r);
        cmd.vld[u8je_pkg::SlotPre+2]   = (cnt_r == 2'd3);
        cmd.units[u8je_pkg::SlotPre+2] = mk(u8je_pkg::KIND_HEX, cont1_r);
        cnt_nxt  = 2'd0;
        do_fresh = 1'b1;
      end

      if (do_fresh) begin
        if (esc != 8'h00) begin
          cmd.vld[u8je_pkg::SlotMid]   = 1'b1;
          cmd.units[u8je_pkg::SlotMid] = mk(u8je_pkg::KIND_ESC2, esc);
        end else if (data_byte >= 8'h20 && data_byte <= 8'h7e) begin
          cmd.vld[u8je_pkg::SlotMid]   = 1'b1;
          cmd.units[u8je_pkg::SlotMid] = mk(u8je_pkg::KIND_LIT, data_byte);
        end else if (data_byte[7] && seq_len(data_byte) != 3'd0) begin
          lead_nxt = data_byte;
          cnt_nxt  = 2'd1;
        end else begin
          cmd.vld[u8je_pkg::SlotMid]   = 1'b1;
          cmd.units[u8je_pkg::SlotMid] = mk(u8je_pkg::KIND_HEX, data_byte);
        end
      end
    end

    // End of string: escape a truncated sequence, close the quote
    if (string_end) begin
      cmd.vld[u8je_pkg::SlotPost]     = (cnt_nxt >= 2'd1);
      cmd.units[u8je_pkg::SlotPost]   = mk(u8je_pkg::KIND_HEX, lead_nxt);
      cmd.vld[u8je_pkg::SlotPost+1]   = (cnt_nxt >= 2'd2);
      cmd.units[u8je_pkg::SlotPost+1] = mk(u8je_pkg::KIND_HEX, cont0_nxt);
      cmd.vld[u8je_pkg::SlotPost+2]   = (cnt_nxt == 2'd3);
      cmd.units[u8je_pkg::SlotPost+2] = mk(u8je_pkg::KIND_HEX, cont1_nxt);
      cmd.vld[u8je_pkg::SlotClose]    = 1'b1;
      cmd.units[u8je_pkg::SlotClose]  = mk(u8je_pkg::KIND_CLOSE, u8je_pkg::ChQuote);
      cnt_nxt  = 2'd0;
      open_nxt = 1'b0;
    end
  end

  assign cmd_push = acc && (|cmd.vld);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else if (acc) begin
      open_r <= open_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Held bytes
  always_ff @(posedge clk) begin
    if (acc) begin
      lead_r  <= lead_nxt;
      cont0_r <= cont0_nxt;
      cont1_r <= cont1_nxt;
    end
  end

endmodule

// ----- rtl/core/u8je_cmdq.sv -----
module u8je_cmdq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  u8je_pkg::cmd_t    din,
  output logic              full,
  input  logic              pop,
  output logic              head_vld,
  output u8je_pkg::cmd_t    head
);

  // Two-entry command queue between front and back
  u8je_pkg::cmd_t ent_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign full     = (cnt_r == 2'd2);
  assign head_vld = (cnt_r != 2'd0);
  assign head     = ent_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && head_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wr_ptr_r] <= din;
  end

endmodule

// ----- rtl/core/u8je_back.sv -----
module u8je_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_vld,
  input  u8je_pkg::cmd_t    head,
  output logic              cmd_pop,
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        out_byte,
  output logic              out_run_last,
  output logic              out_closing_quote
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       close;
  } out_item_t;

  // Serializer state over the head command
  logic [u8je_pkg::NumSlots-1:0] done_r, done_nxt;
  logic [2:0]                    sub_r, sub_nxt;
  logic [u8je_pkg::NumSlots-1:0] pend, rest, cur_oh;
  logic [u8je_pkg::SlotIdxW-1:0] cur;
  u8je_pkg::unit_t               unit;
  logic [2:0]                    last_sub;
  logic                          unit_done, more, emit;
  out_item_t                     item;

  // Output queue, two entries
  out_item_t  oq_r [2];
  logic       oq_wr_r, oq_rd_r;
  logic [1:0] oq_cnt_r;
  logic       oq_full, oq_pop;

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    return (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h57 + {4'd0, v});
  endfunction

  assign pend = head.vld & ~done_r;

  // Lowest pending slot
  always_comb begin
    cur = '0;
    for (int i = u8je_pkg::NumSlots - 1; i >= 0; i--) begin
      if (pend[i]) cur = u8je_pkg::SlotIdxW'(i);
    end
  end

  assign cur_oh = u8je_pkg::NumSlots'(1) << cur;
  assign rest   = pend & ~cur_oh;
  assign more   = |rest;
  assign unit   = head.units[cur];
  assign emit   = head_vld && !oq_full;

  // Expand the current unit
  always_comb begin
    item = '0;
    unique case (unit.kind)
      u8je_pkg::KIND_LIT: begin
        last_sub  = 3'd0;
        item.data = unit.val;
      end
      u8je_pkg::KIND_CLOSE: begin
        last_sub   = 3'd0;
        item.data  = unit.val;
        item.close = 1'b1;
      end
      u8je_pkg::KIND_ESC2: begin
        last_sub  = 3'd1;
        item.data = (sub_r == 3'd0) ? u8je_pkg::ChBslash : unit.val;
      end
      u8je_pkg::KIND_HEX: begin
        last_sub = 3'd5;
        unique case (sub_r)
          3'd0:    item.data = u8je_pkg::ChBslash;
          3'd1:    item.data = 8'h75;  // u
          3'd4:    item.data = hex_char(unit.val[7:4]);
          3'd5:    item.data = hex_char(unit.val[3:0]);
          default: item.data = 8'h30;  // 0
        endcase
      end
      default: begin
        last_sub  = 3'd0;
        item.data = unit.val;
      end
    endcase
    unit_done = (sub_r == last_sub);
    item.last = unit_done && !more;
  end

  // Step through bytes, units and commands
  always_comb begin
    done_nxt = done_r;
    sub_nxt  = sub_r;
    cmd_pop  = 1'b0;
    if (emit) begin
      if (unit_done) begin
        sub_nxt = 3'd0;
        if (more) begin
          done_nxt = done_r | cur_oh;
        end else begin
          done_nxt = '0;
          cmd_pop  = 1'b1;
        end
      end else begin
        sub_nxt = sub_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= '0;
      sub_r  <= 3'd0;
    end else begin
      done_r <= done_nxt;
      sub_r  <= sub_nxt;
    end
  end

  // Output queue
  assign oq_full = (oq_cnt_r == 2'd2);
  assign empty   = (oq_cnt_r == 2'd0);
  assign oq_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= 1'b0;
      oq_rd_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      if (emit)   oq_wr_r <= ~oq_wr_r;
      if (oq_pop) oq_rd_r <= ~oq_rd_r;
      oq_cnt_r <= oq_cnt_r + {1'b0, emit} - {1'b0, oq_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (emit) oq_r[oq_wr_r] <= item;
  end

  assign out_byte          = oq_r[oq_rd_r].data;
  assign out_run_last      = oq_r[oq_rd_r].last;
  assign out_closing_quote = oq_r[oq_rd_r].close;

endmodule

// ----- rtl/core/utf8_json_string_escaper_top.sv -----
// Channel   Handshake           Transfer when     Payload
// input     push / full         push && !full     in_data_byte, in_byte_present, in_string_end
// result    empty / pop         pop && !empty     out_byte, out_run_last, out_closing_quote
//
// One input transfer per cycle while the command queue has room; the output
// serializer sends one byte per cycle while the output queue has room, and
// an item produces 1 byte for plain text and up to 25 bytes in the worst case.
// The first byte of an item is registered in the command queue, then in the output queue.
// Synchronous active-low reset empties both queues and closes the string.
// full rises when two commands wait; a stalled pop backs up the output queue,
// then the serializer, then the command queue.
module utf8_json_string_escaper_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_data_byte,
  input  logic       in_byte_present,
  input  logic       in_string_end,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_closing_quote
);

  logic           acc;
  logic           cmd_push, cmd_pop, head_vld;
  u8je_pkg::cmd_t cmd, head;

  assign acc = push && !full;

  u8je_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (acc),
    .data_byte    (in_data_byte),
    .byte_present (in_byte_present),
    .string_end   (in_string_end),
    .cmd_push     (cmd_push),
    .cmd          (cmd)
  );

  u8je_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .din      (cmd),
    .full     (full),
    .pop      (cmd_pop),
    .head_vld (head_vld),
    .head     (head)
  );

  u8je_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_vld          (head_vld),
    .head              (head),
    .cmd_pop           (cmd_pop),
    .empty             (empty),
    .pop               (pop),
    .out_byte          (out_byte),
    .out_run_last      (out_run_last),
    .out_closing_quote (out_closing_quote)
  );

endmodule

// ----- sim/tb_utf8_json_string_escaper_top.sv -----
module tb_utf8_json_string_escaper_top;

  localparam int MaxCycles   = 400000;
  localparam int MaxShown    = 10;
  localparam int MaxItemText = 25;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       close;
  } json_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_byte_present = 1'b0;
  logic       in_string_end = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte;
  logic       out_run_last;
  logic       out_closing_quote;

  // Escaper state mirror
  bit         str_open = 1'b0;
  logic [7:0] seq_lead = 8'h00;
  logic [7:0] seq_cont [2] = '{8'h00, 8'h00};
  int         seq_held = 0;

  json_byte_t item_text[$];
  json_byte_t json_text_q[$];

  int          cycles = 0;
  int          mismatches = 0;
  int          items_sent = 0;
  int          burst_left = 0;
  logic        draining = 1'b0;
  int unsigned pop_mode = 0;
  int unsigned pop_left = 0;
  logic [15:0] pop_pat = 16'hffff;

  utf8_json_string_escaper_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_data_byte      (in_data_byte),
    .in_byte_present   (in_byte_present),
    .in_string_end     (in_string_end),
    .empty             (empty),
    .pop               (pop),
    .out_byte          (out_byte),
    .out_run_last      (out_run_last),
    .out_closing_quote (out_closing_quote)
  );

  always #2 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == MaxCycles) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Expected JSON text
  // ---------------------------------------------------------------------------
  function automatic void emit(logic [7:0] ch, logic close);
    json_byte_t b;
    b.ch    = ch;
    b.last  = 1'b0;
    b.close = close;
    if (item_text.size() < MaxItemText) item_text = {item_text, b};
  endfunction

  function automatic logic [7:0] hex_digit(logic [3:0] v);
    return (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h57 + {4'd0, v});
  endfunction

  function automatic void emit_hex(logic [7:0] b);
    emit(u8je_pkg::ChBslash, 1'b0);
    emit("u", 1'b0);
    emit("0", 1'b0);
    emit("0", 1'b0);
    emit(hex_digit(b[7:4]), 1'b0);
    emit(hex_digit(b[3:0]), 1'b0);
  endfunction

  // Sequence length implied by a lead byte, 0 if it starts none
  function automatic int utf8_len(logic [7:0] lead);
    if (lead >= 8'hc2 && lead <= 8'hdf) return 2;
    if (lead >= 8'he0 && lead <= 8'hef) return 3;
    if (lead >= 8'hf0 && lead <= 8'hf4) return 4;
    return 0;
  endfunction

  // Second byte is narrowed for overlong, surrogate and above-range leads
  function automatic bit cont_ok(logic [7:0] lead, int pos, logic [7:0] b);
    if (pos == 1) begin
      if (lead == 8'he0) return b >= 8'ha0 && b <= 8'hbf;
      if (lead == 8'hed) return b >= 8'h80 && b <= 8'h9f;
      if (lead == 8'hf0) return b >= 8'h90 && b <= 8'hbf;
      if (lead == 8'hf4) return b >= 8'h80 && b <= 8'h8f;
    end
    return b >= 8'h80 && b <= 8'hbf;
  endfunction

  function automatic void flush_held();
    if (seq_held >= 1) emit_hex(seq_lead);
    if (seq_held >= 2) emit_hex(seq_cont[0]);
    if (seq_held >= 3) emit_hex(seq_cont[1]);
    seq_held = 0;
  endfunction

  function automatic void fresh_byte(logic [7:0] b);
    logic [7:0] letter;
    case (b)
      u8je_pkg::ChQuote:  letter = u8je_pkg::ChQuote;
      u8je_pkg::ChBslash: letter = u8je_pkg::ChBslash;
      8'h08:              letter = "b";
      8'h0c:              letter = "f";
      8'h0a:              letter = "n";
      8'h0d:              letter = "r";
      8'h09:              letter = "t";
      default:            letter = 8'h00;
    endcase
    if (letter != 8'h00) begin
      emit(u8je_pkg::ChBslash, 1'b0);
      emit(letter, 1'b0);
    end else if (b >= 8'h20 && b <= 8'h7e) begin
      emit(b, 1'b0);
    end else if (b >= 8'h80 && utf8_len(b) != 0) begin
      seq_lead = b;
      seq_held = 1;
    end else begin
      emit_hex(b);
    end
  endfunction

  function automatic void take_byte(logic [7:0] b);
    int len;
    if (seq_held == 0) begin
      fresh_byte(b);
      return;
    end
    len = utf8_len(seq_lead);
    if (len != 0 && seq_held < len && cont_ok(seq_lead, seq_held, b)) begin
      if (seq_held + 1 == len) begin
        // sequence complete: release it raw
        emit(seq_lead, 1'b0);
        if (seq_held >= 2) emit(seq_cont[0], 1'b0);
        if (seq_held >= 3) emit(seq_cont[1], 1'b0);
        emit(b, 1'b0);
        seq_held = 0;
      end else begin
        seq_cont[1'(seq_held - 1)] = b;
        seq_held++;
      end
      return;
    end
    // broken: escape what is held, then treat the byte as new
    flush_held();
    fresh_byte(b);
  endfunction

  function automatic void escape_item(logic [7:0] b, logic present, logic fin);
    item_text.delete();
    if ((present || fin) && !str_open) begin
      emit(u8je_pkg::ChQuote, 1'b0);
      str_open = 1'b1;
    end
    if (present) take_byte(b);
    if (fin) begin
      flush_held();
      emit(u8je_pkg::ChQuote, 1'b1);
      str_open = 1'b0;
    end
    if (item_text.size() > 0) item_text[item_text.size() - 1].last = 1'b1;
    json_text_q = {json_text_q, item_text};
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  task automatic send_item(logic [7:0] b, logic present, logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    push            <= 1'b1;
    in_data_byte    <= b;
    in_byte_present <= present;
    in_string_end   <= fin;
    @(posedge clk);
    while (full) @(posedge clk);
    escape_item(b, present, fin);
    if (present || fin) items_sent++;
  endtask

  function automatic logic [7:0] pick_lead();
    case ($urandom_range(0, 4))
      0: return 8'($urandom_range(8'hc2, 8'hdf));
      1: return 8'($urandom_range(8'he0, 8'hef));
      2: return 8'($urandom_range(8'hf0, 8'hf4));
      default: begin
        case ($urandom_range(0, 3))
          0: return 8'he0;
          1: return 8'hed;
          2: return 8'hf0;
          default: return 8'hf4;
        endcase
      end
    endcase
  endfunction

  // Random continuation that keeps the sequence well formed
  function automatic logic [7:0] cont_byte(logic [7:0] lead, int pos);
    if (pos == 1) begin
      if (lead == 8'he0) return 8'($urandom_range(8'ha0, 8'hbf));
      if (lead == 8'hed) return 8'($urandom_range(8'h80, 8'h9f));
      if (lead == 8'hf0) return 8'($urandom_range(8'h90, 8'hbf));
      if (lead == 8'hf4) return 8'($urandom_range(8'h80, 8'h8f));
    end
    return 8'($urandom_range(8'h80, 8'hbf));
  endfunction

  // One quoted string of random, well-formed content
  task automatic send_json_string();
    logic [7:0] text[$];
    logic [7:0] lead;
    logic [7:0] b;
    int         nchars;
    int         len;
    nchars = $urandom_range(0, 10);
    repeat (nchars) begin
      case ($urandom_range(0, 9))
        0, 1, 2: text = {text, 8'($urandom_range(8'h20, 8'h7e))};
        3: begin
          case ($urandom_range(0, 6))
            0: b = u8je_pkg::ChQuote;
            1: b = u8je_pkg::ChBslash;
            2: b = 8'h08;
            3: b = 8'h0c;
            4: b = 8'h0a;
            5: b = 8'h0d;
            default: b = 8'h09;
          endcase
          text = {text, b};
        end
        4: begin
          b = ($urandom_range(0, 4) == 0) ? 8'h7f : 8'($urandom_range(0, 31));
          text = {text, b};
        end
        default: begin
          lead = pick_lead();
          len  = utf8_len(lead);
          text = {text, lead};
          for (int k = 1; k < len; k++) text = {text, cont_byte(lead, k)};
        end
      endcase
    end
    foreach (text[i]) begin
      if ($urandom_range(0, 15) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      if (i == text.size() - 1 && $urandom_range(0, 1) == 0) begin
        send_item(text[i], 1'b1, 1'b1);
        return;
      end
      send_item(text[i], 1'b1, 1'b0);
    end
    send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: the pop stall pattern is redrawn after a random run of cycles
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (pop_left == 0) begin
      pop_mode = $urandom_range(0, 3);
      pop_left = $urandom_range(30, 200);
      pop_pat  = 16'($urandom);
    end
    pop_left--;
    if (draining) begin
      pop <= 1'b1;
    end else begin
      case (pop_mode)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom_range(0, 1));
        2: pop <= pop_pat[cycles[3:0]];
        default: pop <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Compare each output transfer with the oldest expected byte
  always @(posedge clk) begin : result_check
    json_byte_t want;
    if (rst_n && pop && !empty) begin
      if (json_text_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxShown)
          $display("cycle %0d: unexpected output byte %h last %b close %b",
                   cycles, out_byte, out_run_last, out_closing_quote);
      end else begin
        want = json_text_q.pop_front();
        if (out_byte !== want.ch || out_run_last !== want.last ||
            out_closing_quote !== want.close) begin
          mismatches++;
          if (mismatches <= MaxShown)
            $display({"cycle %0d: expected byte %h last %b close %b, ",
                      "got byte %h last %b close %b"},
                     cycles, want.ch, want.last, want.close,
                     out_byte, out_run_last, out_closing_quote);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Directed: {present, end, byte}
  task automatic test_directed();
    logic [9:0] plan [32] = '{
      {2'b00, 8'h41},                                   // idle before the string opens
      {2'b01, 8'h00},                                   // empty string
      {2'b10, 8'h00}, {2'b10, 8'h1f}, {2'b10, 8'h20}, {2'b10, 8'h7e},
      {2'b10, 8'h7f}, {2'b10, 8'h22}, {2'b10, 8'h5c},
      {2'b10, 8'h08}, {2'b10, 8'h0c}, {2'b10, 8'h0a}, {2'b10, 8'h0d}, {2'b10, 8'h09},
      {2'b10, 8'h80}, {2'b10, 8'hff},                   // bad leads
      {2'b10, 8'hc2}, {2'b10, 8'h80},                   // smallest 2-byte
      {2'b10, 8'hed}, {2'b10, 8'h9f}, {2'b10, 8'hbf},   // last below surrogates
      {2'b10, 8'hf4}, {2'b10, 8'h8f}, {2'b10, 8'hbf},   // U+10FFFF with idle inside
      {2'b00, 8'h00}, {2'b10, 8'hbf},
      {2'b10, 8'he0}, {2'b10, 8'h80},                   // overlong breaks
      {2'b10, 8'hf0}, {2'b10, 8'h90}, {2'b10, 8'h80},   // three held, bad byte, end
      {2'b11, 8'hff}
    };
    foreach (plan[i]) send_item(plan[i][7:0], plan[i][9], plan[i][8]);
  endtask

  task automatic test_json_strings(int target);
    int start;
    start = items_sent;
    while (items_sent - start < target) send_json_string();
  endtask

  // Broken and truncated sequences mixed with arbitrary items
  task automatic test_broken_and_noise(int target);
    logic [7:0] lead;
    int         start;
    int         good;
    start = items_sent;
    while (items_sent - start < target) begin
      if ($urandom_range(0, 1) == 0) begin
        lead = pick_lead();
        send_item(lead, 1'b1, 1'b0);
        good = $urandom_range(0, utf8_len(lead) - 2);
        for (int k = 1; k <= good; k++) send_item(cont_byte(lead, k), 1'b1, 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end else begin
        send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 3) == 0);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_json_strings(130);
    test_broken_and_noise(60);
    push     <= 1'b0;
    draining <= 1'b1;
    while (json_text_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
